[design/frt_pkg.sv]
// Shared types and constants of the IPv4 fragment reassembly tracker.
`timescale 1ns / 1ps
package frt_pkg;

  localparam int CONTEXTS_DEF = 16;
  localparam int PIECES_DEF   = 8;

  localparam logic [7:0]  THREADS_RESET = 8'd1;
  localparam logic [15:0] AGE_RESET     = 16'd30;

  typedef enum logic [0:0] {
    CFG_THREAD_COUNT = 1'b0,
    CFG_MAX_AGE      = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_PASS   = 3'd0,
    ST_BAD    = 3'd1,
    ST_STORED = 3'd2,
    ST_DUP    = 3'd3,
    ST_DONE   = 3'd4,
    ST_DROP   = 3'd5,
    ST_FULL   = 3'd6,
    ST_TICK   = 3'd7
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  ip_version;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [15:0] buffer_length;
    logic        more_fragments;
    logic [12:0] frag_offset;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ident;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic        is_fragment;
    status_t     status;
    logic [3:0]  context_slot;
    logic [17:0] reassembled_length;
    logic [7:0]  thread_index;
    logic [4:0]  evicted_count;
  } res_t;

  // One stored piece: header words, total length, offset.
  typedef struct packed {
    logic [3:0]  hw;
    logic [15:0] tl;
    logic [12:0] off;
  } piece_t;

  // Per-context word kept in RAM.
  typedef struct packed {
    logic [63:0] key;
    logic [15:0] ident;
    logic [31:0] birth;
    logic [17:0] size;
  } ctx_t;

endpackage

[design/frt_in_if.sv]
// Input channel: packet header fields or time tick.
`timescale 1ns / 1ps
interface frt_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  ip_version;
  logic [3:0]  header_words;
  logic [15:0] total_length;
  logic [15:0] buffer_length;
  logic        more_fragments;
  logic [12:0] frag_offset;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] ident;
  logic [31:0] now_seconds;

  modport source (output valid, req_type, ip_version, header_words, total_length,
                  buffer_length, more_fragments, frag_offset, src_addr, dst_addr,
                  ident, now_seconds, input ready);
  modport sink (input valid, req_type, ip_version, header_words, total_length,
                buffer_length, more_fragments, frag_offset, src_addr, dst_addr,
                ident, now_seconds, output ready);
endinterface

[design/frt_out_if.sv]
// Result channel of the tracker.
`timescale 1ns / 1ps
interface frt_out_if;
  logic             valid;
  logic             ready;
  logic             is_fragment;
  frt_pkg::status_t status;
  logic [3:0]       context_slot;
  logic [17:0]      reassembled_length;
  logic [7:0]       thread_index;
  logic [4:0]       evicted_count;

  modport source (output valid, is_fragment, status, context_slot, reassembled_length,
                  thread_index, evicted_count, input ready);
  modport sink (input valid, is_fragment, status, context_slot, reassembled_length,
                thread_index, evicted_count, output ready);
endinterface

[design/frt_cfg_if.sv]
// Configuration write channel.
`timescale 1ns / 1ps
interface frt_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/frt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/frt_mod.sv]
// Restoring modulo unit: 32-bit dividend by 8-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module frt_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [7:0]  rem
);
  logic [31:0] dvd_r, dvd_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  d_r, d_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [8:0]  trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[31]};
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      d_nxt   = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift in next bit, subtract when it fits
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = 8'(trial - {1'b0, d_r});
      end else begin
        rem_nxt = trial[7:0];
      end
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule

[design/ipv4_fragment_reassembly_tracker.sv]
// IPv4 fragment reassembly tracker: sequencer over context and piece RAMs.
// Pass and bad headers are answered from idle; a tick reads and checks each context
// in turn; a fragment reads each context scanned, reads pieces in the duplicate, shift
// and completeness walks, opens or inserts, runs the thread modulo, then goes out.
// One item at a time; the RAM read port and the bit-serial modulo set the pace.
// Reset (synchronous, rst_n low) clears contexts, restores register defaults.
`timescale 1ns / 1ps
module ipv4_fragment_reassembly_tracker #(
  parameter int CONTEXTS           = frt_pkg::CONTEXTS_DEF,
  parameter int PIECES_PER_CONTEXT = frt_pkg::PIECES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  frt_in_if.sink    in_ch,
  frt_out_if.source out_ch,
  frt_cfg_if.sink   cfg_ch
);
  localparam int SW    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int CW    = $clog2(PIECES_PER_CONTEXT + 1);
  localparam int PW    = $clog2(PIECES_PER_CONTEXT);
  localparam int DEPTH = CONTEXTS * PIECES_PER_CONTEXT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_TICK_RD  = 14'b00000000000010,
    S_TICK_CHK = 14'b00000000000100,
    S_LK_RD    = 14'b00000000001000,
    S_LK_CHK   = 14'b00000000010000,
    S_NEW      = 14'b00000000100000,
    S_DUP_RD   = 14'b00000001000000,
    S_DUP_CHK  = 14'b00000010000000,
    S_SH_RD    = 14'b00000100000000,
    S_SH_CHK   = 14'b00001000000000,
    S_INS      = 14'b00010000000000,
    S_WALK_RD  = 14'b00100000000000,
    S_WALK_CHK = 14'b01000000000000,
    S_DIV      = 14'b10000000000000
  } state_t;
  // S_OUT folded: results leave from a separate emit flag below.

  state_t              state_r, state_nxt;
  frt_pkg::req_t       req_r, req_nxt;
  frt_pkg::res_t       res_r, res_nxt, out_r;
  logic                out_valid_r, out_valid_nxt;
  logic                emit_r, emit_nxt;
  logic [7:0]          thr_r;
  logic [15:0]         age_r;
  logic [SW-1:0]       idx_r, idx_nxt, free_r, free_nxt, slot_r, slot_nxt;
  logic                free_ok_r, free_ok_nxt;
  logic [AW-1:0]       base_r, base_nxt;
  logic [CW-1:0]       pidx_r, pidx_nxt, cnt_r, cnt_nxt;
  frt_pkg::ctx_t       ctxw_r, ctxw_nxt;
  logic [17:0]         ds_r, ds_nxt;
  logic signed [18:0]  size_r, size_nxt;
  logic signed [19:0]  next_r, next_nxt;
  logic [5:0]          hlen0_r, hlen0_nxt;
  logic [4:0]          evict_r, evict_nxt;
  logic                valid_r [CONTEXTS];
  logic                valid_nxt [CONTEXTS];
  logic                last_r [CONTEXTS];
  logic                last_nxt [CONTEXTS];
  logic [CW-1:0]       pcnt_r [CONTEXTS];
  logic [CW-1:0]       pcnt_nxt [CONTEXTS];

  // RAM ports
  logic                ctx_we;
  logic [SW-1:0]       ctx_waddr;
  frt_pkg::ctx_t       ctx_wdata, ctx_rdata;
  logic                pc_we;
  logic [AW-1:0]       pc_waddr, pc_raddr;
  frt_pkg::piece_t     pc_wdata, pc_rdata;

  // modulo unit
  logic                div_start, div_done;
  logic [7:0]          div_rem, tc;

  // temporaries
  frt_pkg::piece_t     entry;
  logic signed [32:0]  age_diff;
  logic [15:0]         pos;
  logic signed [17:0]  plen;
  logic signed [19:0]  pend;
  logic                in_fire;

  assign in_ch.ready = (state_r == S_IDLE) && !emit_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign tc          = (thr_r == 8'd0) ? 8'd1 : thr_r;
  assign entry       = '{hw: req_r.header_words, tl: req_r.total_length,
                         off: req_r.frag_offset};
  assign pc_raddr    = base_r + AW'(pidx_r[PW-1:0]);
  assign age_diff    = $signed({1'b0, req_r.now_seconds}) - $signed({1'b0, ctx_rdata.birth});
  assign pos         = {pc_rdata.off, 3'b000};
  assign plen        = $signed({2'b00, pc_rdata.tl}) - $signed({12'd0, pc_rdata.hw, 2'b00});
  assign pend        = 20'(plen) + $signed({4'd0, pos});

  frt_ram #(.WIDTH($bits(frt_pkg::ctx_t)), .DEPTH(CONTEXTS)) u_ctx_ram (
    .clk(clk), .we(ctx_we), .waddr(ctx_waddr), .wdata(ctx_wdata),
    .raddr(idx_r), .rdata(ctx_rdata)
  );

  frt_ram #(.WIDTH($bits(frt_pkg::piece_t)), .DEPTH(DEPTH)) u_piece_ram (
    .clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
    .raddr(pc_raddr), .rdata(pc_rdata)
  );

  frt_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(req_r.src_addr ^ req_r.dst_addr), .divisor(tc),
    .done(div_done), .rem(div_rem)
  );

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    res_nxt     = res_r;
    emit_nxt    = 1'b0;
    idx_nxt     = idx_r;
    free_nxt    = free_r;
    free_ok_nxt = free_ok_r;
    slot_nxt    = slot_r;
    base_nxt    = base_r;
    pidx_nxt    = pidx_r;
    cnt_nxt     = cnt_r;
    ctxw_nxt    = ctxw_r;
    ds_nxt      = ds_r;
    size_nxt    = size_r;
    next_nxt    = next_r;
    hlen0_nxt   = hlen0_r;
    evict_nxt   = evict_r;
    valid_nxt   = valid_r;
    last_nxt    = last_r;
    pcnt_nxt    = pcnt_r;
    ctx_we      = 1'b0;
    ctx_waddr   = slot_r;
    ctx_wdata   = ctxw_r;
    pc_we       = 1'b0;
    pc_waddr    = pc_raddr;
    pc_wdata    = entry;
    div_start   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt = '{req_type: in_ch.req_type, ip_version: in_ch.ip_version,
                      header_words: in_ch.header_words, total_length: in_ch.total_length,
                      buffer_length: in_ch.buffer_length,
                      more_fragments: in_ch.more_fragments, frag_offset: in_ch.frag_offset,
                      src_addr: in_ch.src_addr, dst_addr: in_ch.dst_addr,
                      ident: in_ch.ident, now_seconds: in_ch.now_seconds};
          res_nxt     = '0;
          idx_nxt     = '0;
          free_ok_nxt = 1'b0;
          evict_nxt   = '0;
          // datagram size if this is the last piece: offset*8 + payload
          size_nxt = $signed({3'd0, in_ch.frag_offset, 3'b000})
                   + $signed({3'd0, in_ch.total_length})
                   - $signed({13'd0, in_ch.header_words, 2'b00});
          if (in_ch.req_type) begin
            state_nxt = S_TICK_RD;
          end else if (in_ch.ip_version != 4'd4 ||
                       in_ch.total_length > in_ch.buffer_length) begin
            res_nxt.status = frt_pkg::ST_BAD;
            emit_nxt       = 1'b1;
          end else if (!in_ch.more_fragments && in_ch.frag_offset == 13'd0) begin
            res_nxt.status = frt_pkg::ST_PASS;
            emit_nxt       = 1'b1;
          end else begin
            res_nxt.is_fragment = 1'b1;
            state_nxt           = S_LK_RD;
          end
        end
      end

      S_TICK_RD: state_nxt = S_TICK_CHK;

      S_TICK_CHK: begin
        if (valid_r[idx_r] && age_diff > $signed({17'd0, age_r})) begin
          valid_nxt[idx_r] = 1'b0;
          evict_nxt        = evict_r + 5'd1;
        end
        if (idx_r == SW'(CONTEXTS - 1)) begin
          res_nxt.status        = frt_pkg::ST_TICK;
          res_nxt.evicted_count = (valid_r[idx_r] && age_diff > $signed({17'd0, age_r}))
                                  ? evict_r + 5'd1 : evict_r;
          emit_nxt              = 1'b1;
          state_nxt             = S_IDLE;
        end else begin
          idx_nxt   = idx_r + SW'(1);
          state_nxt = S_TICK_RD;
        end
      end

      S_LK_RD: state_nxt = S_LK_CHK;

      S_LK_CHK: begin
        if (valid_r[idx_r] && ctx_rdata.key == {req_r.src_addr, req_r.dst_addr} &&
            ctx_rdata.ident == req_r.ident) begin
          slot_nxt  = idx_r;
          ctxw_nxt  = ctx_rdata;
          ds_nxt    = ctx_rdata.size;
          base_nxt  = AW'(AW'(idx_r) * AW'(PIECES_PER_CONTEXT));
          pidx_nxt  = '0;
          cnt_nxt   = pcnt_r[idx_r];
          res_nxt.context_slot = 4'(idx_r);
          state_nxt = S_DUP_RD;
        end else begin
          if (!valid_r[idx_r] && !free_ok_r) begin
            free_nxt    = idx_r;
            free_ok_nxt = 1'b1;
          end
          if (idx_r == SW'(CONTEXTS - 1)) begin
            state_nxt = S_NEW;
          end else begin
            idx_nxt   = idx_r + SW'(1);
            state_nxt = S_LK_RD;
          end
        end
      end

      S_NEW: begin
        state_nxt = S_IDLE;
        emit_nxt  = 1'b1;
        if (!free_ok_r) begin
          res_nxt.status = frt_pkg::ST_FULL;
        end else begin
          // open a context in the free slot with this piece first
          res_nxt.context_slot = 4'(free_r);
          ctx_we    = 1'b1;
          ctx_waddr = free_r;
          ctx_wdata = '{key: {req_r.src_addr, req_r.dst_addr}, ident: req_r.ident,
                        birth: req_r.now_seconds, size: size_r[17:0]};
          pc_we     = 1'b1;
          pc_waddr  = AW'(AW'(free_r) * AW'(PIECES_PER_CONTEXT));
          pcnt_nxt[free_r] = CW'(1);
          last_nxt[free_r] = !req_r.more_fragments;
          valid_nxt[free_r] = 1'b1;
          res_nxt.status = frt_pkg::ST_STORED;
          if (!req_r.more_fragments && size_r[18]) begin
            valid_nxt[free_r] = 1'b0;
            res_nxt.status    = frt_pkg::ST_DROP;
          end
        end
      end

      S_DUP_RD: state_nxt = S_DUP_CHK;

      S_DUP_CHK: begin
        if (pc_rdata.off == req_r.frag_offset) begin
          res_nxt.status = frt_pkg::ST_DUP;
          emit_nxt       = 1'b1;
          state_nxt      = S_IDLE;
        end else if (pidx_r != cnt_r - CW'(1)) begin
          pidx_nxt  = pidx_r + CW'(1);
          state_nxt = S_DUP_RD;
        end else if (cnt_r >= CW'(PIECES_PER_CONTEXT)) begin
          res_nxt.status = frt_pkg::ST_FULL;
          emit_nxt       = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          // insertion sort from the tail
          pidx_nxt  = cnt_r - CW'(1);
          state_nxt = S_SH_RD;
        end
      end

      S_SH_RD: state_nxt = S_SH_CHK;

      S_SH_CHK: begin
        // pidx_r now points at the piece just read
        if (pc_rdata.off > req_r.frag_offset) begin
          pc_we     = 1'b1;
          pc_waddr  = pc_raddr + AW'(1);
          pc_wdata  = pc_rdata;
          if (pidx_r == '0) begin
            state_nxt = S_INS;
          end else begin
            pidx_nxt  = pidx_r - CW'(1);
            state_nxt = S_SH_RD;
          end
        end else begin
          pidx_nxt  = pidx_r + CW'(1);
          state_nxt = S_INS;
        end
      end

      S_INS: begin
        pc_we    = 1'b1;
        pcnt_nxt[slot_r] = cnt_r + CW'(1);
        cnt_nxt  = cnt_r + CW'(1);
        pidx_nxt = '0;
        next_nxt = '0;
        res_nxt.status = frt_pkg::ST_STORED;
        if (!req_r.more_fragments && size_r[18]) begin
          valid_nxt[slot_r] = 1'b0;
          res_nxt.status    = frt_pkg::ST_DROP;
          emit_nxt          = 1'b1;
          state_nxt         = S_IDLE;
        end else if (!req_r.more_fragments) begin
          last_nxt[slot_r] = 1'b1;
          ds_nxt           = size_r[17:0];
          ctx_we           = 1'b1;
          ctx_wdata        = '{key: ctxw_r.key, ident: ctxw_r.ident,
                               birth: ctxw_r.birth, size: size_r[17:0]};
          state_nxt        = S_WALK_RD;
        end else if (last_r[slot_r]) begin
          state_nxt = S_WALK_RD;
        end else begin
          emit_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_WALK_RD: state_nxt = S_WALK_CHK;

      S_WALK_CHK: begin
        if (pidx_r == '0) begin
          hlen0_nxt = {pc_rdata.hw, 2'b00};
        end
        if (pidx_r == '0 && ds_r == 18'd0 && pc_rdata.hw == 4'd0) begin
          emit_nxt  = 1'b1;               // empty datagram: wait
          state_nxt = S_IDLE;
        end else if (next_r < $signed({4'd0, pos})) begin
          emit_nxt  = 1'b1;               // gap: wait
          state_nxt = S_IDLE;
        end else if (next_r > $signed({4'd0, pos}) || pend > $signed({2'b00, ds_r})) begin
          valid_nxt[slot_r] = 1'b0;       // overlap or overrun: drop
          res_nxt.status    = frt_pkg::ST_DROP;
          emit_nxt          = 1'b1;
          state_nxt         = S_IDLE;
        end else if (pidx_r == cnt_r - CW'(1)) begin
          valid_nxt[slot_r] = 1'b0;
          res_nxt.status    = frt_pkg::ST_DONE;
          res_nxt.reassembled_length = ds_r + 18'((pidx_r == '0) ?
                                       {pc_rdata.hw, 2'b00} : hlen0_r);
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          next_nxt  = next_r + 20'(plen);
          pidx_nxt  = pidx_r + CW'(1);
          state_nxt = S_WALK_RD;
        end
      end

      S_DIV: begin
        if (div_done) begin
          res_nxt.thread_index = div_rem;
          emit_nxt             = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Result register: load on emit once the previous transfer is gone.
  assign out_valid_nxt = emit_r ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      emit_r      <= 1'b0;
      thr_r       <= frt_pkg::THREADS_RESET;
      age_r       <= frt_pkg::AGE_RESET;
      for (int i = 0; i < CONTEXTS; i++) begin
        valid_r[i] <= 1'b0;
        last_r[i]  <= 1'b0;
        pcnt_r[i]  <= '0;
      end
    end else begin
      // hold emit until the output register is free
      if (emit_r && out_valid_r && !out_ch.ready) begin
        emit_r      <= 1'b1;
        out_valid_r <= 1'b1;
      end else begin
        emit_r      <= emit_nxt;
        out_valid_r <= out_valid_nxt;
      end
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
      pcnt_r  <= pcnt_nxt;
      if (cfg_ch.valid) begin
        unique case (frt_pkg::cfg_idx_t'(cfg_ch.index))
          frt_pkg::CFG_THREAD_COUNT: thr_r <= cfg_ch.data[7:0];
          frt_pkg::CFG_MAX_AGE:      age_r <= cfg_ch.data;
        endcase
      end
    end
    if (emit_r && !(out_valid_r && !out_ch.ready)) begin
      out_r <= res_r;
    end
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    idx_r     <= idx_nxt;
    free_r    <= free_nxt;
    free_ok_r <= free_ok_nxt;
    slot_r    <= slot_nxt;
    base_r    <= base_nxt;
    pidx_r    <= pidx_nxt;
    cnt_r     <= cnt_nxt;
    ctxw_r    <= ctxw_nxt;
    ds_r      <= ds_nxt;
    size_r    <= size_nxt;
    next_r    <= next_nxt;
    hlen0_r   <= hlen0_nxt;
    evict_r   <= evict_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.is_fragment        = out_r.is_fragment;
  assign out_ch.status             = out_r.status;
  assign out_ch.context_slot       = out_r.context_slot;
  assign out_ch.reassembled_length = out_r.reassembled_length;
  assign out_ch.thread_index       = out_r.thread_index;
  assign out_ch.evicted_count      = out_r.evicted_count;
endmodule

[test/frt_checker.sv]
// Result checker for the IPv4 fragment reassembly tracker: predicts and compares.
`timescale 1ns / 1ps
module frt_checker (
  input  logic       clk,
  input  logic       rst_n,
  frt_in_if.sink     in_mon,
  frt_out_if.sink    out_mon,
  frt_cfg_if.sink    cfg_mon,
  output int         fail_count,
  output int         pending
);
  import frt_pkg::*;

  localparam int NCTX = 16;
  localparam int NPC  = 8;

  logic [7:0]  threads;
  logic [15:0] age_limit;
  logic        live [NCTX];
  logic [63:0] key_tab [NCTX];
  logic [15:0] id_tab [NCTX];
  logic [31:0] birth_tab [NCTX];
  logic        last_seen [NCTX];
  int          dgram_size [NCTX];
  int          npieces [NCTX];
  piece_t      pieces [NCTX][NPC];
  res_t        expected_q [$];

  function automatic int payload_len(piece_t p);
    return int'(p.tl) - 4 * int'(p.hw);
  endfunction

  // 0 wait, 1 complete, 2 broken
  function automatic int scan_coverage(int s);
    int next;
    int pos;
    next = 0;
    if (dgram_size[s] + 4 * int'(pieces[s][0].hw) == 0) return 0;
    for (int i = 0; i < npieces[s]; i++) begin
      pos = 8 * int'(pieces[s][i].off);
      if (next < pos) return 0;
      if (next > pos || payload_len(pieces[s][i]) + pos > dgram_size[s]) return 2;
      next += payload_len(pieces[s][i]);
    end
    return 1;
  endfunction

  function automatic res_t track_header(req_t r);
    res_t   o;
    int     found;
    int     freeslot;
    int     s;
    int     i;
    int     sz;
    int     w;
    piece_t e;
    logic [63:0] k;
    logic [31:0] tc;
    o = '0;
    o.status = ST_PASS;
    if (r.req_type) begin
      for (int c = 0; c < NCTX; c++)
        if (live[c] && (longint'(r.now_seconds) - longint'(birth_tab[c]) >
                        longint'(age_limit))) begin
          live[c] = 1'b0;
          o.evicted_count++;
        end
      o.status = ST_TICK;
      return o;
    end
    if (r.ip_version != 4 || r.total_length > r.buffer_length) begin
      o.status = ST_BAD;
      return o;
    end
    if (!r.more_fragments && r.frag_offset == 0) return o;
    o.is_fragment = 1'b1;
    k = {r.src_addr, r.dst_addr};
    e = '{hw: r.header_words, tl: r.total_length, off: r.frag_offset};
    sz = 8 * int'(r.frag_offset) + int'(r.total_length) - 4 * int'(r.header_words);
    found = -1;
    freeslot = -1;
    for (int c = 0; c < NCTX; c++) begin
      if (live[c]) begin
        if (found < 0 && key_tab[c] == k && id_tab[c] == r.ident) found = c;
      end else if (freeslot < 0) freeslot = c;
    end
    if (found < 0) begin
      if (freeslot < 0) begin
        o.status = ST_FULL;
        return o;
      end
      s = freeslot;
      o.context_slot = s[3:0];
      live[s] = 1'b1;
      key_tab[s] = k;
      id_tab[s] = r.ident;
      birth_tab[s] = r.now_seconds;
      last_seen[s] = 1'b0;
      npieces[s] = 1;
      pieces[s][0] = e;
      o.status = ST_STORED;
      if (!r.more_fragments) begin
        if (sz < 0) begin
          live[s] = 1'b0;
          o.status = ST_DROP;
        end else begin
          last_seen[s] = 1'b1;
          dgram_size[s] = sz;
        end
      end
      return o;
    end
    s = found;
    o.context_slot = s[3:0];
    for (int j = 0; j < npieces[s]; j++)
      if (pieces[s][j].off == r.frag_offset) begin
        o.status = ST_DUP;
        return o;
      end
    if (npieces[s] >= NPC) begin
      o.status = ST_FULL;
      return o;
    end
    i = npieces[s];
    while (i > 0 && pieces[s][i-1].off > r.frag_offset) begin
      pieces[s][i] = pieces[s][i-1];
      i--;
    end
    pieces[s][i] = e;
    npieces[s]++;
    if (!r.more_fragments) begin
      if (sz < 0) begin
        live[s] = 1'b0;
        o.status = ST_DROP;
        return o;
      end
      last_seen[s] = 1'b1;
      dgram_size[s] = sz;
    end
    o.status = ST_STORED;
    if (last_seen[s]) begin
      w = scan_coverage(s);
      if (w == 2) begin
        live[s] = 1'b0;
        o.status = ST_DROP;
      end else if (w == 1) begin
        tc = (threads == 0) ? 32'd1 : 32'(threads);
        o.status = ST_DONE;
        o.reassembled_length = 18'(dgram_size[s] + 4 * int'(pieces[s][0].hw));
        o.thread_index = 8'((r.src_addr ^ r.dst_addr) % tc);
        live[s] = 1'b0;
      end
    end
    return o;
  endfunction

  req_t req_now;
  res_t got;
  res_t want;

  assign req_now = '{in_mon.req_type, in_mon.ip_version, in_mon.header_words,
                     in_mon.total_length, in_mon.buffer_length, in_mon.more_fragments,
                     in_mon.frag_offset, in_mon.src_addr, in_mon.dst_addr,
                     in_mon.ident, in_mon.now_seconds};
  assign got = '{out_mon.is_fragment, out_mon.status, out_mon.context_slot,
                 out_mon.reassembled_length, out_mon.thread_index, out_mon.evicted_count};
  assign pending = expected_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      threads <= THREADS_RESET;
      age_limit <= AGE_RESET;
      for (int c = 0; c < NCTX; c++) begin
        live[c] = 1'b0;
        last_seen[c] = 1'b0;
        npieces[c] = 0;
      end
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_THREAD_COUNT) threads <= cfg_mon.data[7:0];
        else age_limit <= cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready) expected_q.push_back(track_header(req_now));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("mismatch: unexpected result %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end
endmodule

[test/tb_top.sv]
// Testbench top for the IPv4 fragment reassembly tracker: stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import frt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   long_hold;
  bit   stall_on;

  frt_in_if  in_ch();
  frt_out_if out_ch();
  frt_cfg_if cfg_ch();

  ipv4_fragment_reassembly_tracker u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  frt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_mon(cfg_ch.sink), .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Stall the result side on its own pattern; a long hold-off backs up the block.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (long_hold) out_ch.ready <= 1'b0;
    else if (stall_on) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= 1'b1;
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || long_hold)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus time base and the pools of flows that random fragments share.
  logic [31:0] clock_sec;
  logic [31:0] flow_src [4];
  logic [31:0] flow_dst [4];
  logic [15:0] flow_id [4];

  task automatic send(req_t r);
    in_ch.valid <= 1'b1;
    {in_ch.req_type, in_ch.ip_version, in_ch.header_words, in_ch.total_length,
     in_ch.buffer_length, in_ch.more_fragments, in_ch.frag_offset, in_ch.src_addr,
     in_ch.dst_addr, in_ch.ident, in_ch.now_seconds} <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t frag(int f, int off, int payload, bit mf, int hw);
    req_t r;
    r = '0;
    r.ip_version = 4'd4;
    r.header_words = 4'(hw);
    r.total_length = 16'(payload + 4 * hw);
    r.buffer_length = r.total_length;
    r.more_fragments = mf;
    r.frag_offset = 13'(off);
    r.src_addr = flow_src[f];
    r.dst_addr = flow_dst[f];
    r.ident = flow_id[f];
    r.now_seconds = clock_sec;
    return r;
  endfunction

  function automatic req_t tick_req(logic [31:0] t);
    req_t r;
    r = '0;
    r.req_type = 1'b1;
    r.now_seconds = t;
    return r;
  endfunction

  function automatic req_t noise_req();
    req_t r;
    r = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.req_type = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 1)) r.ip_version = 4'd4;
    return r;
  endfunction

  // Wait for every expected result, then let the block settle before a register write.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send one datagram split into pieces, in random order, sometimes broken.
  task automatic send_datagram(int f);
    int n;
    int hw;
    int unit [8];
    int offs [8];
    int order [8];
    int tmp;
    int j;
    req_t r;
    n = $urandom_range(1, 5);
    hw = $urandom_range(5, 15);
    offs[0] = 0;
    for (int i = 0; i < n; i++) begin
      unit[i] = $urandom_range(1, 20);
      if (i > 0) offs[i] = offs[i-1] + unit[i-1];
      order[i] = i;
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      j = order[i];
      r = frag(f, offs[j], 8 * unit[j], (j != n - 1), hw);
      case ($urandom_range(0, 19))
        0: r.frag_offset = r.frag_offset + 13'd1;
        1: r.total_length = r.total_length + 16'd8;
        2: r.more_fragments = 1'b0;
        3: ;
        default: ;
      endcase
      if (n == 1 && r.frag_offset == 0) r.more_fragments = 1'b1;
      send(r);
      if ($urandom_range(0, 9) == 0) send(r);
      if ($urandom_range(0, 3) == 0) begin
        pause_input();
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic random_phase(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < count; b++) begin
        clock_sec = clock_sec + $urandom_range(0, 3);
        case ($urandom_range(0, 9))
          0: begin send(noise_req()); sent++; end
          1: begin send(tick_req(clock_sec)); sent++; end
          default: begin
            send_datagram($urandom_range(0, 3));
            flow_id[$urandom_range(0, 3)] = 16'($urandom);
            sent += 3;
          end
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        pause_input();
        repeat ($urandom_range(0, 15)) @(posedge clk);
      end
    end
  endtask

  req_t r;

  initial begin
    rst_n = 1'b0;
    long_hold = 1'b0;
    stall_on = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.req_type, in_ch.ip_version, in_ch.header_words, in_ch.total_length,
     in_ch.buffer_length, in_ch.more_fragments, in_ch.frag_offset, in_ch.src_addr,
     in_ch.dst_addr, in_ch.ident, in_ch.now_seconds} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_THREAD_COUNT;
    cfg_ch.data = '0;
    clock_sec = 32'd100;
    for (int f = 0; f < 4; f++) begin
      flow_src[f] = $urandom;
      flow_dst[f] = $urandom;
      flow_id[f] = 16'($urandom);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: headers, ticks and the corner cases of the tracker.
    r = frag(0, 0, 40, 0, 5);             send(r);  // plain packet passes
    r.ip_version = 4'd6;                  send(r);  // wrong version
    r = frag(0, 0, 40, 0, 5);
    r.buffer_length = r.total_length - 16'd1; send(r);  // truncated capture
    r = frag(0, 0, 0, 0, 0);
    r.total_length = 16'hFFFF; r.buffer_length = 16'hFFFF;
    r.src_addr = '1; r.dst_addr = '1; r.ident = '1; send(r);
    send(frag(0, 0, 16, 1, 5));                     // first piece
    send(frag(0, 0, 16, 1, 5));                     // duplicate offset
    send(frag(0, 4, 8, 1, 5));                      // gap waits
    send(frag(0, 2, 16, 0, 5));                     // last piece; the piece at offset 4 overruns: drop
    send(frag(1, 1, -60, 0, 15));                   // negative size on a new context
    send(frag(1, 0, 24, 1, 5));
    send(frag(1, 2, 16, 0, 5));                     // overlap drops
    send(frag(2, 0, 0, 0, 0));                      // unfragmented zero header
    r = frag(2, 8191, 0, 1, 15); r.total_length = 16'hFFFF; r.buffer_length = '1;
    send(r);                                        // extreme offset and length
    send(frag(3, 0, 0, 1, 0));
    send(frag(3, 1, 0, 0, 0));                      // gap before the last piece waits
    for (int i = 0; i < 9; i++) send(frag(2, i, 8, 1, 5));  // piece table full
    send(tick_req(32'hFFFF_FFFF));                  // age everything out
    send(tick_req(32'd0));                          // time before birth
    for (int i = 0; i < 17; i++) begin              // context table full
      flow_id[0] = 16'(i);
      send(frag(0, 1, 8, 1, 5));
    end
    send(tick_req(32'hFFFF_FFFF));

    // Random phases across register settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      quiesce();
      case (ph)
        0: begin write_reg(CFG_THREAD_COUNT, 16'd255); write_reg(CFG_MAX_AGE, 16'd1); end
        1: begin write_reg(CFG_THREAD_COUNT, 16'd0); write_reg(CFG_MAX_AGE, 16'd65535); end
        2: begin write_reg(CFG_THREAD_COUNT, 16'd1); write_reg(CFG_MAX_AGE, 16'd30); end
        3: begin
          write_reg(CFG_THREAD_COUNT, 16'($urandom_range(2, 254)));
          write_reg(CFG_MAX_AGE, 16'($urandom_range(2, 200)));
        end
        default: begin write_reg(CFG_THREAD_COUNT, 16'd7); write_reg(CFG_MAX_AGE, 16'd10); end
      endcase
      stall_on = (ph % 2 == 0);
      if (ph == 2) begin
        // Hold the result side off while items keep coming.
        long_hold = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            long_hold = 1'b0;
          end
          random_phase(12);
        join
      end
      random_phase(300);
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
